### rtl/tsss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared widths, operation codes and sequencer states of the two-sided
// sparse set.
// ----------------------------------------------------------------------------
package tsss_pkg;

   localparam int DEF_CAPACITY = 1024;

   localparam int OP_W   = 4;
   localparam int ELEM_W = 10;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 11;
   localparam int MARK_W = 11;

   typedef enum logic [OP_W-1:0] {
      OP_ADD           = 4'd0,
      OP_REMOVE_BACK   = 4'd1,
      OP_REMOVE_FRONT  = 4'd2,
      OP_CONTAIN       = 4'd3,
      OP_POSITION_OF   = 4'd4,
      OP_NEXT          = 4'd5,
      OP_PREV          = 4'd6,
      OP_READ          = 4'd7,
      OP_POP_BACK      = 4'd8,
      OP_POP_FRONT     = 4'd9,
      OP_FILL          = 4'd10,
      OP_CLEAR         = 4'd11,
      OP_RESTORE_END   = 4'd12,
      OP_RESTORE_START = 4'd13
   } tsss_op_type;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SLOT  = 6'b000100,
      ST_LOOK  = 6'b001000,
      ST_SWAP1 = 6'b010000,
      ST_SWAP2 = 6'b100000
   } tsss_state_type;

endpackage

### rtl/tsss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/two_sided_sparse_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_sparse_set
// Sparse set over elements 0..CAPACITY-1 with front-removed, member and back
// regions, held in two RAMs (slot -> element, element -> slot).
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one result word, shown on the rsp_ ports for one cycle with rsp_strobe high.
// The receiver cannot stall, so the result must be captured on that cycle.
// After reset the block runs a clearing pass that writes the identity
// permutation into both RAMs, one entry a cycle, with busy high throughout.
// Each word first reads the slot of its element from place_of, a registered
// read, in ST_SLOT. Next, prev and read that find an entry then fetch it
// from element_at in ST_LOOK. Add and remove that move an element read the
// element at the target slot in ST_SLOT, then swap in ST_SWAP1 and ST_SWAP2,
// which write two entries of each RAM, one per state, through the single
// write port. Busy is high until the word is done; the strobe shows as busy
// falls, so the next word may be offered straight away and is taken at the
// edge that ends the strobe.
// ----------------------------------------------------------------------------
module two_sided_sparse_set #(
   parameter int CAPACITY = tsss_pkg::DEF_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tsss_pkg::OP_W-1:0]    req_operation,
   input  logic [tsss_pkg::ELEM_W-1:0]  req_element,
   input  logic [tsss_pkg::POS_W-1:0]   req_position,
   output logic                         rsp_strobe,
   output logic                         rsp_found,
   output logic [tsss_pkg::VAL_W-1:0]   rsp_value,
   output logic [tsss_pkg::MARK_W-1:0]  rsp_start_mark,
   output logic [tsss_pkg::MARK_W-1:0]  rsp_end_mark,
   output logic                         rsp_error
);

   import tsss_pkg::*;

   // Slot / element width, mark width (marks reach CAPACITY itself), and the
   // width in which marks are compared with the 11-bit position field.
   localparam int AW = $clog2(CAPACITY);
   localparam int MW = $clog2(CAPACITY + 1);
   localparam int CW = (MW > POS_W) ? MW : POS_W;

   // Sequencer and marks
   tsss_state_type    state_ff, state_in;
   logic [AW-1:0]     init_cnt_ff, init_cnt_in;
   logic [MW-1:0]     start_ff, start_in;
   logic [MW-1:0]     end_ff, end_in;

   // Latched word and working values
   logic [OP_W-1:0]   op_ff;
   logic [ELEM_W-1:0] elem_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              valid_ff;
   logic              found_ff, found_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [AW-1:0]     target_ff, target_in;

   // Result register
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [MARK_W-1:0] rsp_start_ff, rsp_end_ff;
   logic              rsp_error_ff, rsp_error_in;

   // RAM ports
   logic              pl_wr_en, ea_wr_en;
   logic [AW-1:0]     pl_wr_addr, pl_wr_data, pl_rd_addr, pl_rd_data;
   logic [AW-1:0]     ea_wr_addr, ea_wr_data, ea_rd_addr, ea_rd_data;

   // Decode helpers
   logic              accept;
   logic [MW-1:0]     slot_m, size_m;
   logic              member;
   logic [CW-1:0]     read_sum;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // place_of: element -> slot
   tsss_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_place_of (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (pl_wr_addr),
      .wr_data (pl_wr_data),
      .rd_addr (pl_rd_addr),
      .rd_data (pl_rd_data)
   );

   // element_at: slot -> element
   tsss_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_element_at (
      .clock   (clock),
      .wr_en   (ea_wr_en),
      .wr_addr (ea_wr_addr),
      .wr_data (ea_wr_data),
      .rd_addr (ea_rd_addr),
      .rd_data (ea_rd_data)
   );

   // Slot lookup is always addressed by the incoming element.
   assign pl_rd_addr = AW'(req_element);

   always_comb begin
      slot_m   = MW'(pl_rd_data);
      size_m   = end_ff - start_ff;
      member   = valid_ff && (slot_m >= start_ff) && (slot_m < end_ff);
      read_sum = CW'(start_ff) + CW'(pos_ff);

      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      target_in     = target_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = found_ff;
      rsp_value_in  = '0;
      rsp_error_in  = 1'b0;

      ea_rd_addr = AW'(read_sum);
      pl_wr_en   = 1'b0;
      pl_wr_addr = slot_ff;
      pl_wr_data = slot_ff;
      ea_wr_en   = 1'b0;
      ea_wr_addr = slot_ff;
      ea_wr_data = slot_ff;

      case (state_ff)
         ST_INIT: begin
            // identity permutation, one entry per cycle
            pl_wr_en    = 1'b1;
            pl_wr_addr  = init_cnt_ff;
            pl_wr_data  = init_cnt_ff;
            ea_wr_en    = 1'b1;
            ea_wr_addr  = init_cnt_ff;
            ea_wr_data  = init_cnt_ff;
            init_cnt_in = init_cnt_ff + AW'(1);
            if (init_cnt_ff == AW'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            found_in      = member;
            rsp_found_in  = member;
            slot_in       = pl_rd_data;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            case (op_ff)
               OP_ADD: begin
                  if (valid_ff) begin
                     if (slot_m >= end_ff) begin
                        target_in     = AW'(end_ff);
                        ea_rd_addr    = AW'(end_ff);
                        end_in        = end_ff + MW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_SWAP1;
                     end else if (slot_m < start_ff) begin
                        target_in     = AW'(start_ff - MW'(1));
                        ea_rd_addr    = AW'(start_ff - MW'(1));
                        start_in      = start_ff - MW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_SWAP1;
                     end
                  end
               end
               OP_REMOVE_BACK: begin
                  if (member) begin
                     target_in     = AW'(end_ff - MW'(1));
                     ea_rd_addr    = AW'(end_ff - MW'(1));
                     end_in        = end_ff - MW'(1);
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_SWAP1;
                  end
               end
               OP_REMOVE_FRONT: begin
                  if (member) begin
                     target_in     = AW'(start_ff);
                     ea_rd_addr    = AW'(start_ff);
                     start_in      = start_ff + MW'(1);
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_SWAP1;
                  end
               end
               OP_CONTAIN: begin
               end
               OP_POSITION_OF: begin
                  if (valid_ff) begin
                     rsp_value_in = VAL_W'(pl_rd_data);
                  end
               end
               OP_NEXT: begin
                  rsp_value_in = VAL_W'(elem_ff);
                  if (valid_ff && ((slot_m + MW'(1)) < end_ff)) begin
                     ea_rd_addr    = AW'(slot_m + MW'(1));
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_LOOK;
                  end
               end
               OP_PREV: begin
                  rsp_value_in = VAL_W'(elem_ff);
                  if (valid_ff && (slot_m > start_ff)) begin
                     ea_rd_addr    = AW'(slot_m - MW'(1));
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_LOOK;
                  end
               end
               OP_READ: begin
                  if (CW'(pos_ff) < CW'(size_m)) begin
                     ea_rd_addr    = AW'(read_sum);
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_LOOK;
                  end else begin
                     rsp_error_in = 1'b1;
                  end
               end
               OP_POP_BACK: begin
                  if (end_ff == start_ff) begin
                     rsp_error_in = 1'b1;
                  end else begin
                     end_in = end_ff - MW'(1);
                  end
               end
               OP_POP_FRONT: begin
                  if (end_ff == start_ff) begin
                     rsp_error_in = 1'b1;
                  end else begin
                     start_in = start_ff + MW'(1);
                  end
               end
               OP_FILL: begin
                  end_in   = MW'(CAPACITY);
                  start_in = '0;
               end
               OP_CLEAR: begin
                  end_in   = '0;
                  start_in = '0;
               end
               OP_RESTORE_END: begin
                  if ((CW'(pos_ff) >= CW'(start_ff)) && (CW'(pos_ff) <= CW'(CAPACITY))) begin
                     end_in = MW'(pos_ff);
                  end else begin
                     rsp_error_in = 1'b1;
                  end
               end
               OP_RESTORE_START: begin
                  if (CW'(pos_ff) <= CW'(end_ff)) begin
                     start_in = MW'(pos_ff);
                  end else begin
                     rsp_error_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_LOOK: begin
            rsp_value_in  = VAL_W'(ea_rd_data);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SWAP1: begin
            // the displaced element takes the old slot of the moving one
            pl_wr_en   = 1'b1;
            pl_wr_addr = ea_rd_data;
            pl_wr_data = slot_ff;
            ea_wr_en   = 1'b1;
            ea_wr_addr = slot_ff;
            ea_wr_data = ea_rd_data;
            state_in   = ST_SWAP2;
         end
         ST_SWAP2: begin
            pl_wr_en      = 1'b1;
            pl_wr_addr    = AW'(elem_ff);
            pl_wr_data    = target_ff;
            ea_wr_en      = 1'b1;
            ea_wr_addr    = target_ff;
            ea_wr_data    = AW'(elem_ff);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_cnt_ff   <= '0;
         start_ff      <= '0;
         end_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         elem_ff  <= req_element;
         pos_ff   <= req_position;
         valid_ff <= (32'(req_element) < 32'(CAPACITY));
      end
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_start_ff <= MARK_W'(start_in);
      rsp_end_ff   <= MARK_W'(end_in);
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_start_mark = rsp_start_ff;
   assign rsp_end_mark   = rsp_end_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

### test/two_sided_sparse_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_sparse_set_tb
// Self-checking bench for the two-sided sparse set: a behavioural copy of
// both stores and both marks predicts every result word, which is compared
// field by field with what the block returns. Directed words first, then
// bursty random traffic biased towards members and saved marks.
// ----------------------------------------------------------------------------
module two_sided_sparse_set_tb;
   import tsss_pkg::*;

   localparam int CAP          = DEF_CAPACITY;
   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPLY_SLOTS  = 16;
   // Slowest legal run: the clearing pass, then under 900 words, each with its
   // busy states and a gap before it; the limit lies far above that.
   localparam int CYCLE_LIMIT  = 200000;

   // codes the block has no operation for; they must change nothing and give a zero value and no error
   localparam logic [OP_W-1:0] OP_SPARE_A = 4'd14;
   localparam logic [OP_W-1:0] OP_SPARE_B = 4'd15;

   typedef struct packed {
      logic              found;
      logic [VAL_W-1:0]  value;
      logic [MARK_W-1:0] start_mark;
      logic [MARK_W-1:0] end_mark;
      logic              error;
   } set_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_operation = '0;
   logic [ELEM_W-1:0]  req_element = '0;
   logic [POS_W-1:0]   req_position = '0;
   logic               rsp_strobe;
   logic               rsp_found;
   logic [VAL_W-1:0]   rsp_value;
   logic [MARK_W-1:0]  rsp_start_mark;
   logic [MARK_W-1:0]  rsp_end_mark;
   logic               rsp_error;

   // predicted contents of the block: slot -> element, element -> slot, marks
   logic [ELEM_W-1:0]  elem_in_slot [CAP];
   logic [ELEM_W-1:0]  slot_of_elem [CAP];
   logic [MARK_W-1:0]  start_q;
   logic [MARK_W-1:0]  end_q;
   // marks captured from earlier replies, replayed by the restore words
   logic [MARK_W-1:0]  saved_start = '0;
   logic [MARK_W-1:0]  saved_end = '0;

   // expected replies in order, as a ring with running write and read counts
   set_reply_type      reply_ring [REPLY_SLOTS];
   int unsigned        reply_wr_count = 0;
   int unsigned        reply_rd_count = 0;

   int unsigned        cycle_count = 0;
   int unsigned        words_sent = 0;
   int unsigned        replies_seen = 0;
   int unsigned        refused_seen = 0;
   int unsigned        fault_count = 0;
   logic [15:0]        ops_seen = '0;

   two_sided_sparse_set #(
      .CAPACITY(CAP)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_element    (req_element),
      .req_position   (req_position),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_value      (rsp_value),
      .rsp_start_mark (rsp_start_mark),
      .rsp_end_mark   (rsp_end_mark),
      .rsp_error      (rsp_error)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Hard stop in case the block hangs or drops a word.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d replies outstanding",
                  cycle_count, reply_wr_count - reply_rd_count);
         $display("two_sided_sparse_set regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Put elem in slot target; whatever sat there takes elem's old slot.
   function automatic void move_elem(input int unsigned elem, input int unsigned target);
      int unsigned from;
      int unsigned other;
      from = slot_of_elem[elem];
      other = elem_in_slot[target];
      slot_of_elem[other] = ELEM_W'(from);
      elem_in_slot[from] = ELEM_W'(other);
      elem_in_slot[target] = ELEM_W'(elem);
      slot_of_elem[elem] = ELEM_W'(target);
   endfunction

   // Apply one word to the predicted set and return the reply it should give.
   function automatic set_reply_type apply_set_op(input logic [OP_W-1:0] op,
                                                  input logic [ELEM_W-1:0] elem,
                                                  input logic [POS_W-1:0] pos);
      set_reply_type reply;
      bit            in_range;
      bit            member;
      int unsigned   slot;
      reply = '0;
      in_range = elem < CAP;
      slot = in_range ? 32'(slot_of_elem[elem]) : 0;
      member = in_range && slot >= start_q && slot < end_q;
      case (op)
         OP_ADD: begin
            if (in_range) begin
               if (slot >= end_q) begin
                  // back element joins at the end of the members
                  move_elem(elem, end_q);
                  end_q = end_q + 1'b1;
               end else if (slot < start_q) begin
                  // front-removed element joins just before start
                  start_q = start_q - 1'b1;
                  move_elem(elem, start_q);
               end
            end
         end
         OP_REMOVE_BACK: begin
            if (member) begin
               end_q = end_q - 1'b1;
               move_elem(elem, end_q);
            end
         end
         OP_REMOVE_FRONT: begin
            if (member) begin
               move_elem(elem, start_q);
               start_q = start_q + 1'b1;
            end
         end
         OP_POSITION_OF: reply.value = VAL_W'(slot);
         OP_NEXT: begin
            reply.value = VAL_W'(elem);
            if (in_range && slot + 1 < end_q)
               reply.value = VAL_W'(elem_in_slot[slot + 1]);
         end
         OP_PREV: begin
            reply.value = VAL_W'(elem);
            if (in_range && slot > start_q)
               reply.value = VAL_W'(elem_in_slot[slot - 1]);
         end
         OP_READ: begin
            if (pos < end_q - start_q)
               reply.value = VAL_W'(elem_in_slot[start_q + pos]);
            else
               reply.error = 1'b1;
         end
         OP_POP_BACK: begin
            if (end_q == start_q)
               reply.error = 1'b1;
            else
               end_q = end_q - 1'b1;
         end
         OP_POP_FRONT: begin
            if (end_q == start_q)
               reply.error = 1'b1;
            else
               start_q = start_q + 1'b1;
         end
         OP_FILL: begin
            start_q = '0;
            end_q = MARK_W'(CAP);
         end
         OP_CLEAR: begin
            start_q = '0;
            end_q = '0;
         end
         OP_RESTORE_END: begin
            if (pos >= start_q && pos <= CAP)
               end_q = pos;
            else
               reply.error = 1'b1;
         end
         OP_RESTORE_START: begin
            if (pos <= end_q)
               start_q = pos;
            else
               reply.error = 1'b1;
         end
         default: ;   // contain and spare codes change nothing
      endcase
      reply.found = member;
      reply.start_mark = start_q;
      reply.end_mark = end_q;
      return reply;
   endfunction

   // ------------------------------------------------------------------------
   // Driving and checking
   // ------------------------------------------------------------------------

   // Offer one word from the falling edge; it is taken at the first rising
   // edge that sees busy low. start is left high so a following word can go
   // straight out; callers drop it for a gap.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] elem,
                            input logic [POS_W-1:0] pos);
      set_reply_type reply;
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_element <= elem;
      req_position <= pos;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      reply = apply_set_op(op, elem, pos);
      reply_ring[reply_wr_count % REPLY_SLOTS] = reply;
      reply_wr_count++;
      words_sent++;
      ops_seen[op] = 1'b1;
      if (reply.error)
         refused_seen++;
   endtask

   task automatic report_fault(input string msg);
      fault_count++;
      $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string what, input logic [VAL_W-1:0] got,
                              input logic [VAL_W-1:0] want);
      if (got !== want)
         report_fault($sformatf("reply %0d %s: got %0d, expected %0d",
                                replies_seen, what, got, want));
   endtask

   // A reply shows for one cycle only, so it is taken on every strobe.
   always @(posedge clock) begin : check_replies
      set_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         replies_seen++;
         if (reply_wr_count == reply_rd_count) begin
            report_fault($sformatf("reply %0d with no word outstanding", replies_seen));
         end else begin
            want = reply_ring[reply_rd_count % REPLY_SLOTS];
            reply_rd_count++;
            check_field("found", rsp_found, want.found);
            check_field("value", rsp_value, want.value);
            check_field("start_mark", rsp_start_mark, want.start_mark);
            check_field("end_mark", rsp_end_mark, want.end_mark);
            check_field("error", rsp_error, want.error);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Refusals and neighbour lookups while nothing is a member.
   task automatic test_empty_set();
      send_word(OP_READ, 0, 0);            // read past size
      send_word(OP_POP_BACK, 0, 0);        // pop with no members
      send_word(OP_NEXT, 7, 0);            // no neighbour: echoes the element
   endtask

   // Adds, removes and lookups over a three-element set.
   task automatic test_membership();
      send_word(OP_ADD, 0, 0);
      send_word(OP_ADD, 1023, 0);          // highest element
      send_word(OP_ADD, 5, 0);
      send_word(OP_ADD, 5, 0);             // already a member: no change
      send_word(OP_CONTAIN, 5, 0);
      send_word(OP_POSITION_OF, 1023, 0);
      send_word(OP_NEXT, 0, 0);
      send_word(OP_PREV, 0, 0);            // first member has no predecessor
      send_word(OP_READ, 0, 2);            // last member
      send_word(OP_READ, 0, 3);            // exactly at size
      send_word(OP_REMOVE_FRONT, 0, 0);
      send_word(OP_ADD, 0, 0);             // front-removed element comes back
      send_word(OP_REMOVE_FRONT, 0, 0);
      send_word(OP_REMOVE_BACK, 1023, 0);
      send_word(OP_REMOVE_BACK, 1023, 0);  // no longer a member
      send_word(OP_PREV, 1023, 0);         // non-member still sees a neighbour
   endtask

   // Mark restores, fill, clear and the unused codes.
   task automatic test_marks();
      send_word(OP_RESTORE_END, 0, 0);             // below start
      send_word(OP_RESTORE_START, 0, 4);           // above end
      send_word(OP_RESTORE_END, 0, 2047);          // beyond capacity
      send_word(OP_FILL, 0, 0);
      send_word(OP_RESTORE_START, 0, POS_W'(CAP)); // empty set at the top
      send_word(OP_POP_FRONT, 0, 0);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_SPARE_A, 1023, 2047);
      send_word(OP_SPARE_B, 0, 0);
   endtask

   // Bursty random traffic. Elements lean towards current members and a small
   // pool so that adds and removes keep hitting each other; positions lean
   // towards valid offsets and marks saved from earlier replies.
   task automatic test_random_traffic(input int unsigned n_words);
      int unsigned       burst_left;
      int unsigned       roll;
      int unsigned       size;
      logic [OP_W-1:0]   op;
      logic [ELEM_W-1:0] elem;
      logic [POS_W-1:0]  pos;
      burst_left = 0;
      repeat (n_words) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(20, 60);    // back-to-back stretch
            end else begin
               burst_left = $urandom_range(1, 10);
               // gap with start low; junk on the fields must be ignored
               @(negedge clock);
               start <= 1'b0;
               req_operation <= OP_W'($urandom_range(0, 15));
               req_element <= ELEM_W'($urandom_range(0, 1023));
               req_position <= POS_W'($urandom_range(0, 2047));
               repeat ($urandom_range(0, 5)) @(negedge clock);
            end
         end
         burst_left--;

         size = end_q - start_q;
         roll = $urandom_range(0, 99);
         if (roll < 25)       op = OP_ADD;
         else if (roll < 33)  op = OP_REMOVE_BACK;
         else if (roll < 41)  op = OP_REMOVE_FRONT;
         else if (roll < 47)  op = OP_CONTAIN;
         else if (roll < 53)  op = OP_POSITION_OF;
         else if (roll < 59)  op = OP_NEXT;
         else if (roll < 65)  op = OP_PREV;
         else if (roll < 73)  op = OP_READ;
         else if (roll < 78)  op = OP_POP_BACK;
         else if (roll < 83)  op = OP_POP_FRONT;
         else if (roll < 85)  op = OP_FILL;
         else if (roll < 87)  op = OP_CLEAR;
         else if (roll < 92)  op = OP_RESTORE_END;
         else if (roll < 98)  op = OP_RESTORE_START;
         else                 op = roll[0] ? OP_SPARE_B : OP_SPARE_A;

         roll = $urandom_range(0, 9);
         if (roll < 4 && size != 0)
            elem = elem_in_slot[start_q + $urandom_range(0, size - 1)];
         else if (roll < 5 && start_q != 0)
            elem = elem_in_slot[$urandom_range(0, start_q - 1)];
         else if (roll < 8)
            elem = ELEM_W'($urandom_range(0, 31));
         else
            elem = ELEM_W'($urandom_range(0, CAP - 1));

         roll = $urandom_range(0, 9);
         case (op)
            OP_RESTORE_END: begin
               if (roll < 5)       pos = POS_W'($urandom_range(start_q, CAP));
               else if (roll < 7)  pos = saved_end;
               else                pos = POS_W'($urandom_range(0, 2047));
            end
            OP_RESTORE_START: begin
               if (roll < 5)       pos = POS_W'($urandom_range(0, end_q));
               else if (roll < 7)  pos = saved_start;
               else                pos = POS_W'($urandom_range(0, 2047));
            end
            default: begin
               if (roll < 7 && size != 0)  pos = POS_W'($urandom_range(0, size - 1));
               else if (roll < 8)          pos = POS_W'(size);
               else                        pos = POS_W'($urandom_range(0, 2047));
            end
         endcase

         send_word(op, elem, pos);
         // now and then remember the marks, as software saving state would
         if ($urandom_range(0, 9) == 0) begin
            saved_start = start_q;
            saved_end = end_q;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < CAP; i++) begin
         elem_in_slot[i] = ELEM_W'(i);
         slot_of_elem[i] = ELEM_W'(i);
      end
      start_q = '0;
      end_q = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the first word also waits out the clearing pass after reset
      test_empty_set();
      test_membership();
      test_marks();
      test_random_traffic(RANDOM_WORDS);

      @(negedge clock);
      start <= 1'b0;
      while (reply_wr_count != reply_rd_count)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent (%0d refused), %0d replies checked, %0d faults",
               words_sent, refused_seen, replies_seen, fault_count);
      $display("%0d of 16 operation codes exercised, final marks %0d..%0d",
               $countones(ops_seen), start_q, end_q);
      if (fault_count == 0)
         $display("two_sided_sparse_set regression: pass");
      else
         $display("two_sided_sparse_set regression: fail");
      $finish;
   end

endmodule

### two_sided_sparse_set.f
rtl/tsss_pkg.sv
rtl/tsss_ram.sv
rtl/two_sided_sparse_set.sv
test/two_sided_sparse_set_tb.sv
